### hw/rtl/pdsel_pkg.sv
// Package for the source PDO selector: payload structs, configuration struct,
// register indexes and PDO type and selection-mode codes.
// No dependencies.
package pdsel_pkg;

    localparam int MAX_OBJECTS_DEF = 7;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_REQUEST_MV = 3'd0;
    localparam logic [2:0] REG_BOARD_MV   = 3'd1;
    localparam logic [2:0] REG_BOARD_MA   = 3'd2;
    localparam logic [2:0] REG_BOARD_MW   = 3'd3;
    localparam logic [2:0] REG_MODE       = 3'd4;
    localparam logic [2:0] REG_CONVERTER  = 3'd5;
    localparam logic [2:0] REG_PREF_MV    = 3'd6;
    localparam logic [2:0] REG_WANTED_MW  = 3'd7;

    localparam logic [1:0] PDO_BATTERY   = 2'd1;
    localparam logic [1:0] PDO_AUGMENTED = 2'd3;

    localparam logic [1:0] MODE_POWER    = 2'd0;
    localparam logic [1:0] MODE_LOW_TIE  = 2'd1;
    localparam logic [1:0] MODE_HIGH_TIE = 2'd2;
    localparam logic [1:0] MODE_DESIRED  = 2'd3;

    localparam logic [1:0] CONV_NONE  = 2'd0;
    localparam logic [1:0] CONV_BUCK  = 2'd1;
    localparam logic [1:0] CONV_BOOST = 2'd2;

    typedef struct packed {
        logic [31:0] pdo_word;
        logic        is_last;
    } t_item;

    typedef struct packed {
        logic [2:0]  chosen_index;
        logic [31:0] chosen_word;
    } t_result;

    typedef struct packed {
        logic [15:0] lim_mv;
        logic [13:0] board_ma;
        logic [27:0] cap_uw;
        logic [1:0]  mode;
        logic [1:0]  conv;
        logic [15:0] pref_mv;
        logic [27:0] want_uw;
    } t_cfg;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  slot;
        logic        first;
        logic        last;
        logic        ok;
        logic [15:0] mv;
        logic [27:0] uw;
    } t_job;

endpackage

### hw/rtl/pdsel_regs.sv
// Configuration registers of the source PDO selector behind an APB-style port.
// Also keeps the derived voltage limit and power values in microwatts.
// Depends on pdsel_pkg.
module pdsel_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pdsel_pkg::ADDR_W-1:0] paddr,
    input  logic [pdsel_pkg::DATA_W-1:0] pwdata,
    output logic [pdsel_pkg::DATA_W-1:0] prdata,
    output logic                          pready,
    output pdsel_pkg::t_cfg               o_cfg
);

    logic [15:0] r_req_mv, n_req_mv;
    logic [15:0] r_brd_mv, n_brd_mv;
    logic [13:0] r_brd_ma, n_brd_ma;
    logic [17:0] r_brd_mw, n_brd_mw;
    logic [1:0]  r_mode, n_mode;
    logic [1:0]  r_conv, n_conv;
    logic [15:0] r_pref_mv, n_pref_mv;
    logic [17:0] r_want_mw, n_want_mw;
    logic [15:0] r_lim_mv;
    logic [27:0] r_cap_uw;
    logic [27:0] r_want_uw;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        n_req_mv  = r_req_mv;
        n_brd_mv  = r_brd_mv;
        n_brd_ma  = r_brd_ma;
        n_brd_mw  = r_brd_mw;
        n_mode    = r_mode;
        n_conv    = r_conv;
        n_pref_mv = r_pref_mv;
        n_want_mw = r_want_mw;
        if (wr_en) begin
            unique case (paddr[4:2])
                pdsel_pkg::REG_REQUEST_MV: n_req_mv  = pwdata[15:0];
                pdsel_pkg::REG_BOARD_MV:   n_brd_mv  = pwdata[15:0];
                pdsel_pkg::REG_BOARD_MA:   n_brd_ma  = pwdata[13:0];
                pdsel_pkg::REG_BOARD_MW:   n_brd_mw  = pwdata[17:0];
                pdsel_pkg::REG_MODE:       n_mode    = pwdata[1:0];
                pdsel_pkg::REG_CONVERTER:  n_conv    = pwdata[1:0];
                pdsel_pkg::REG_PREF_MV:    n_pref_mv = pwdata[15:0];
                pdsel_pkg::REG_WANTED_MW:  n_want_mw = pwdata[17:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_mv  <= 16'd20000;
            r_brd_mv  <= 16'd20000;
            r_brd_ma  <= 14'd3000;
            r_brd_mw  <= 18'd60000;
            r_mode    <= pdsel_pkg::MODE_POWER;
            r_conv    <= pdsel_pkg::CONV_NONE;
            r_pref_mv <= 16'd9000;
            r_want_mw <= 18'd0;
            r_lim_mv  <= 16'd20000;
            r_cap_uw  <= 28'd60000000;
            r_want_uw <= 28'd0;
        end else begin
            r_req_mv  <= n_req_mv;
            r_brd_mv  <= n_brd_mv;
            r_brd_ma  <= n_brd_ma;
            r_brd_mw  <= n_brd_mw;
            r_mode    <= n_mode;
            r_conv    <= n_conv;
            r_pref_mv <= n_pref_mv;
            r_want_mw <= n_want_mw;
            r_lim_mv  <= (n_req_mv < n_brd_mv) ? n_req_mv : n_brd_mv;
            r_cap_uw  <= {10'd0, n_brd_mw} * 28'd1000;
            r_want_uw <= {10'd0, n_want_mw} * 28'd1000;
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            pdsel_pkg::REG_REQUEST_MV: prdata = {16'd0, r_req_mv};
            pdsel_pkg::REG_BOARD_MV:   prdata = {16'd0, r_brd_mv};
            pdsel_pkg::REG_BOARD_MA:   prdata = {18'd0, r_brd_ma};
            pdsel_pkg::REG_BOARD_MW:   prdata = {14'd0, r_brd_mw};
            pdsel_pkg::REG_MODE:       prdata = {30'd0, r_mode};
            pdsel_pkg::REG_CONVERTER:  prdata = {30'd0, r_conv};
            pdsel_pkg::REG_PREF_MV:    prdata = {16'd0, r_pref_mv};
            pdsel_pkg::REG_WANTED_MW:  prdata = {14'd0, r_want_mw};
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg.lim_mv   = r_lim_mv;
    assign o_cfg.board_ma = r_brd_ma;
    assign o_cfg.cap_uw   = r_cap_uw;
    assign o_cfg.mode     = r_mode;
    assign o_cfg.conv     = r_conv;
    assign o_cfg.pref_mv  = r_pref_mv;
    assign o_cfg.want_uw  = r_want_uw;

endmodule

### hw/rtl/pdsel_front.sv
// Front end of the source PDO selector: accepts PDO words, decodes and
// qualifies them, and computes the clamped power over two pipeline stages.
// Depends on pdsel_pkg.
module pdsel_front #(
    parameter int MAX_OBJECTS = pdsel_pkg::MAX_OBJECTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pdsel_pkg::t_cfg       i_cfg,
    input  logic                  i_in_valid,
    input  pdsel_pkg::t_item      i_in_data,
    output logic                  o_in_stall,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output pdsel_pkg::t_job       o_q_data
);

    localparam int CW = $clog2(MAX_OBJECTS + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_OBJECTS);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  slot;
        logic        first;
        logic        last;
        logic        ok;
        logic        bat;
        logic [15:0] mv;
        logic [13:0] ma;
        logic [27:0] bat_uw;
    } t_dec;

    logic [CW-1:0]   r_count;
    logic            r_s1_valid;
    t_dec            r_s1;
    logic            r_s2_valid;
    pdsel_pkg::t_job r_s2;

    logic            accept;
    logic            s1_adv;
    logic            s2_free;
    t_dec            n_s1;
    logic [9:0]      fld_v;
    logic [9:0]      fld_c;
    logic [1:0]      kind;
    logic [13:0]     ma_raw;
    logic [29:0]     prod;
    logic [29:0]     raw_uw;

    assign s2_free    = !r_s2_valid || !i_q_full;
    assign s1_adv     = r_s1_valid && s2_free;
    assign o_in_stall = r_s1_valid && !s2_free;
    assign accept     = i_in_valid && !o_in_stall;

    assign fld_v  = i_in_data.pdo_word[19:10];
    assign fld_c  = i_in_data.pdo_word[9:0];
    assign kind   = i_in_data.pdo_word[31:30];
    assign ma_raw = {4'd0, fld_c} * 14'd10;

    always_comb begin
        n_s1.word   = i_in_data.pdo_word;
        n_s1.slot   = 3'(r_count);
        n_s1.first  = (r_count == '0);
        n_s1.last   = i_in_data.is_last;
        n_s1.mv     = {6'd0, fld_v} * 16'd50;
        n_s1.ok     = (r_count < COUNT_MAX) && (kind != pdsel_pkg::PDO_AUGMENTED)
                      && (fld_v != 10'd0) && (n_s1.mv <= i_cfg.lim_mv);
        n_s1.bat    = (kind == pdsel_pkg::PDO_BATTERY);
        n_s1.ma     = (ma_raw > i_cfg.board_ma) ? i_cfg.board_ma : ma_raw;
        n_s1.bat_uw = {18'd0, fld_c} * 28'd250000;
    end

    assign prod   = {16'd0, r_s1.ma} * {14'd0, r_s1.mv};
    assign raw_uw = r_s1.bat ? {2'd0, r_s1.bat_uw} : prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (i_in_data.is_last) begin
                    r_count <= '0;
                end else if (r_count < COUNT_MAX) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (!r_s1_valid || s1_adv) begin
                r_s1_valid <= accept;
            end
            if (s2_free) begin
                r_s2_valid <= s1_adv;
            end
        end
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_s2.word  <= r_s1.word;
            r_s2.slot  <= r_s1.slot;
            r_s2.first <= r_s1.first;
            r_s2.last  <= r_s1.last;
            r_s2.ok    <= r_s1.ok;
            r_s2.mv    <= r_s1.mv;
            r_s2.uw    <= (raw_uw > {2'd0, i_cfg.cap_uw}) ? i_cfg.cap_uw : raw_uw[27:0];
        end
    end

    assign o_q_push = r_s2_valid && !i_q_full;
    assign o_q_data = r_s2;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_MAX)
        else $error("item counter passed the object limit");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_data.is_last |=> r_count == '0)
        else $error("item counter not cleared after a last object");

endmodule

### hw/rtl/pdsel_fifo.sv
// Short queue between the front end and the selection back end of the
// source PDO selector. Depends on pdsel_pkg.
module pdsel_fifo #(
    parameter int DEPTH = pdsel_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pdsel_pkg::t_job i_data,
    input  logic            i_pop,
    output pdsel_pkg::t_job o_head,
    output logic            o_full,
    output logic            o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [NW-1:0] NUM_FULL = NW'(DEPTH);

    pdsel_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [NW-1:0]   r_num;

    assign o_full  = (r_num == NUM_FULL);
    assign o_empty = (r_num == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_num    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_num <= r_num + 1'b1;
            end else if (i_pop && !i_push) begin
                r_num <= r_num - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from an empty queue");

endmodule

### hw/rtl/pdsel_back.sv
// Back end of the source PDO selector: keeps the running best object by the
// configured rule and registers the result on the last object of a list.
// Depends on pdsel_pkg.
module pdsel_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pdsel_pkg::t_cfg     i_cfg,
    input  logic                i_q_empty,
    input  pdsel_pkg::t_job     i_q_head,
    output logic                o_q_pop,
    output logic                o_out_valid,
    output pdsel_pkg::t_result  o_out_data,
    input  logic                i_out_stall
);

    typedef struct packed {
        logic [2:0]  slot;
        logic [27:0] uw;
        logic [15:0] mv;
        logic [31:0] word;
    } t_best;

    t_best              r_best;
    t_best              base;
    t_best              n_best;
    logic               r_out_valid;
    pdsel_pkg::t_result r_out;
    logic               out_free;
    logic               wins;
    logic               gt;
    logic               eq;
    logic               conv_win;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_q_pop  = !i_q_empty && (!i_q_head.last || out_free);

    always_comb begin
        if (i_q_head.first) begin
            base.slot = 3'd0;
            base.uw   = 28'd0;
            base.mv   = 16'd0;
            base.word = i_q_head.word;
        end else begin
            base = r_best;
        end
    end

    assign gt = i_q_head.uw > base.uw;
    assign eq = i_q_head.uw == base.uw;

    always_comb begin
        case (i_cfg.conv)
            pdsel_pkg::CONV_BUCK:
                conv_win = (i_q_head.mv >= i_cfg.pref_mv && i_q_head.mv < base.mv)
                           || (base.mv < i_cfg.pref_mv && i_q_head.mv > base.mv);
            pdsel_pkg::CONV_BOOST:
                conv_win = (i_q_head.mv <= i_cfg.pref_mv && i_q_head.mv > base.mv)
                           || (base.mv > i_cfg.pref_mv && i_q_head.mv < base.mv);
            default:
                conv_win = 1'b0;
        endcase
    end

    always_comb begin
        unique case (i_cfg.mode)
            pdsel_pkg::MODE_LOW_TIE:  wins = gt || (eq && i_q_head.mv < base.mv);
            pdsel_pkg::MODE_HIGH_TIE: wins = gt || (eq && i_q_head.mv > base.mv);
            pdsel_pkg::MODE_DESIRED: begin
                if (i_q_head.uw >= i_cfg.want_uw) begin
                    wins = (base.uw < i_cfg.want_uw) || conv_win;
                end else begin
                    wins = (base.uw == 28'd0) || gt;
                end
            end
            default:                  wins = gt;
        endcase
    end

    always_comb begin
        n_best = base;
        if (i_q_head.ok && wins) begin
            n_best.slot = i_q_head.slot;
            n_best.uw   = i_q_head.uw;
            n_best.mv   = i_q_head.mv;
            n_best.word = i_q_head.word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_best <= i_q_head.last ? '0 : n_best;
            end
            if (o_q_pop && i_q_head.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_q_pop && i_q_head.last) begin
            r_out.chosen_index <= n_best.slot;
            r_out.chosen_word  <= n_best.word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_out_valid && i_out_stall && o_q_pop && i_q_head.last))
        else $error("pending result overwritten");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop && i_q_head.last |=> r_out_valid)
        else $error("last object did not produce a result");

endmodule

### hw/rtl/pd_source_pdo_selector_unit.sv
// Top level of the source PDO selector: configuration registers, front end,
// queue and selection back end. Depends on pdsel_pkg and the pdsel_* modules.
//
//   Channel   Direction  Handshake              Payload
//   in        input      i_in_valid/o_in_stall  i_in_data  (pdo_word, is_last)
//   out       output     o_out_valid/i_out_stall o_out_data (chosen_index, chosen_word)
//   config    input      psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// One object is accepted per cycle while o_in_stall is low; after its last object is accepted,
// a result passes through the two front stages, the queue and the result register.
// Synchronous active-low reset clears all control state; no clearing pass is needed.
// A stalled result register holds back only the next last object; others keep
// flowing until the queue fills, then o_in_stall rises.
module pd_source_pdo_selector_unit #(
    parameter int MAX_OBJECTS = pdsel_pkg::MAX_OBJECTS_DEF,
    parameter int QUEUE_DEPTH = pdsel_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  pdsel_pkg::t_item              i_in_data,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output pdsel_pkg::t_result            o_out_data,
    input  logic                          i_out_stall,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pdsel_pkg::ADDR_W-1:0] paddr,
    input  logic [pdsel_pkg::DATA_W-1:0] pwdata,
    output logic [pdsel_pkg::DATA_W-1:0] prdata,
    output logic                          pready
);

    pdsel_pkg::t_cfg cfg;
    pdsel_pkg::t_job q_in;
    pdsel_pkg::t_job q_head;
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;

    pdsel_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pdsel_front #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_in)
    );

    pdsel_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    pdsel_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
